[rtl/core/nca_pkg.sv]
package nca_pkg;

   localparam int ID_BITS      = 24;
   localparam int SLOT_BITS    = 8;
   localparam int NEAREST_BITS = 8;
   localparam int COUNT_BITS   = 9;
   localparam int DIST_BITS    = 49;

   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // stages between the last table read and the final best update
   localparam int DRAIN_CYCLES = 4;
   localparam int DRAIN_BITS   = 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  load;
      logic                  capture;
      logic                  issue;
      logic [COUNT_BITS-1:0] rd_idx;
      logic                  emit;
      logic                  empty;
   } cmd_type;

endpackage

[rtl/core/nca_ram.sv]
module nca_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256,
   localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [WIDTH-1:0]    rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/nca_ctrl.sv]
module nca_ctrl #(
   parameter int MAX_CENTERS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            req_type,
   input  logic                            csr_valid,
   input  logic [nca_pkg::COUNT_BITS-1:0]  csr_data,
   output logic                            csr_ready,
   output logic                            busy,
   output nca_pkg::cmd_type                cmd
);

   nca_pkg::state_type state_ff, state_in;
   logic [nca_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [nca_pkg::COUNT_BITS-1:0] idx_ff, idx_in;
   logic [nca_pkg::DRAIN_BITS-1:0] drain_ff, drain_in;
   logic accept;
   logic last_idx;

   assign accept   = start && (state_ff == nca_pkg::ST_IDLE);
   assign last_idx = (idx_ff == (count_ff - nca_pkg::COUNT_BITS'(1)));

   // center_count saturates at the table depth
   always_comb begin
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         count_in = (32'(csr_data) > MAX_CENTERS) ?
                    nca_pkg::COUNT_BITS'(MAX_CENTERS) : csr_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nca_pkg::ST_IDLE: begin
            if (accept && (req_type == nca_pkg::REQ_QUERY)) begin
               state_in = (count_ff == '0) ? nca_pkg::ST_EMIT : nca_pkg::ST_SCAN;
            end
         end
         nca_pkg::ST_SCAN: begin
            if (last_idx) begin
               state_in = nca_pkg::ST_DRAIN;
            end
         end
         nca_pkg::ST_DRAIN: begin
            if (drain_ff == '0) begin
               state_in = nca_pkg::ST_EMIT;
            end
         end
         nca_pkg::ST_EMIT: begin
            state_in = nca_pkg::ST_IDLE;
         end
         default: begin
            state_in = nca_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      drain_in = drain_ff;
      unique case (state_ff)
         nca_pkg::ST_IDLE: begin
            idx_in = '0;
         end
         nca_pkg::ST_SCAN: begin
            idx_in   = idx_ff + nca_pkg::COUNT_BITS'(1);
            drain_in = nca_pkg::DRAIN_BITS'(nca_pkg::DRAIN_CYCLES - 1);
         end
         nca_pkg::ST_DRAIN: begin
            drain_in = drain_ff - nca_pkg::DRAIN_BITS'(1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      busy        = (state_ff != nca_pkg::ST_IDLE);
      csr_ready   = (state_ff == nca_pkg::ST_IDLE);
      cmd.load    = accept && (req_type == nca_pkg::REQ_LOAD);
      cmd.capture = accept && (req_type == nca_pkg::REQ_QUERY);
      cmd.issue   = (state_ff == nca_pkg::ST_SCAN);
      cmd.rd_idx  = idx_ff;
      cmd.emit    = (state_ff == nca_pkg::ST_EMIT);
      cmd.empty   = (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nca_pkg::ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         drain_ff <= drain_in;
      end
   end

   a_scan_has_centers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nca_pkg::ST_SCAN) |-> (count_ff != '0))
      else $error("scan with no centers");

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (cmd.rd_idx < count_ff))
      else $error("table read beyond center_count");

   a_emit_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (state_ff == nca_pkg::ST_IDLE))
      else $error("emit not followed by idle");

endmodule

[rtl/core/nca_dp.sv]
module nca_dp #(
   parameter int MAX_CENTERS = 256,
   parameter int COORD_BITS  = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  nca_pkg::cmd_type                  cmd,
   input  logic signed [COORD_BITS-1:0]      req_coord_x,
   input  logic signed [COORD_BITS-1:0]      req_coord_y,
   input  logic [nca_pkg::SLOT_BITS-1:0]     req_slot,
   input  logic [nca_pkg::ID_BITS-1:0]       req_point_id,
   output logic                              rsp_valid,
   output logic [nca_pkg::ID_BITS-1:0]       rsp_point_tag,
   output logic [nca_pkg::NEAREST_BITS-1:0]  rsp_nearest,
   output logic [nca_pkg::DIST_BITS-1:0]     rsp_dist_sq,
   output logic                              rsp_no_center
);

   localparam int AddrBits = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
   localparam int SqBits   = 2 * COORD_BITS;
   localparam int SumBits  = (SqBits + 1 > nca_pkg::DIST_BITS + 1) ?
                             SqBits + 1 : nca_pkg::DIST_BITS + 1;
   localparam int CB       = COORD_BITS;
   localparam int IB       = nca_pkg::COUNT_BITS;

   logic [CB-1:0] qx_ff, qy_ff;
   logic [nca_pkg::ID_BITS-1:0] qid_ff;

   logic            wr_en;
   logic [2*CB-1:0] rd_data;
   logic [CB-1:0]   cx, cy, px_off, py_off, cx_off, cy_off;

   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [IB-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic [CB-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SqBits-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [SumBits-1:0] sum;
   logic [nca_pkg::DIST_BITS-1:0] d_ff, d_in;
   logic [nca_pkg::DIST_BITS-1:0] best_d_ff;
   logic [IB-1:0] best_idx_ff;
   logic          take;

   logic                              rsp_valid_ff;
   logic [nca_pkg::ID_BITS-1:0]       tag_ff;
   logic [nca_pkg::NEAREST_BITS-1:0]  nearest_ff;
   logic [nca_pkg::DIST_BITS-1:0]     dist_ff;
   logic                              no_center_ff;

   assign wr_en = cmd.load && (32'(req_slot) < MAX_CENTERS);

   nca_ram #(
      .WIDTH (2 * CB),
      .DEPTH (MAX_CENTERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AddrBits'(req_slot)),
      .wr_data ({req_coord_x, req_coord_y}),
      .rd_addr (AddrBits'(cmd.rd_idx)),
      .rd_data (rd_data)
   );

   // offset binary orders like unsigned
   assign cx     = rd_data[2*CB-1:CB];
   assign cy     = rd_data[CB-1:0];
   assign px_off = {~qx_ff[CB-1], qx_ff[CB-2:0]};
   assign py_off = {~qy_ff[CB-1], qy_ff[CB-2:0]};
   assign cx_off = {~cx[CB-1], cx[CB-2:0]};
   assign cy_off = {~cy[CB-1], cy[CB-2:0]};

   assign dx_in = (px_off >= cx_off) ? (px_off - cx_off) : (cx_off - px_off);
   assign dy_in = (py_off >= cy_off) ? (py_off - cy_off) : (cy_off - py_off);
   assign sx_in = SqBits'(dx_ff) * SqBits'(dx_ff);
   assign sy_in = SqBits'(dy_ff) * SqBits'(dy_ff);
   assign sum   = SumBits'(sx_ff) + SumBits'(sy_ff);
   assign d_in  = (sum > SumBits'(nca_pkg::DIST_MAX)) ?
                  nca_pkg::DIST_MAX : nca_pkg::DIST_BITS'(sum);

   // strict compare keeps the lowest index on ties
   assign take = s4_valid_ff && ((s4_idx_ff == '0) || (d_ff < best_d_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         qx_ff  <= req_coord_x;
         qy_ff  <= req_coord_y;
         qid_ff <= req_point_id;
      end
      s1_idx_ff <= cmd.rd_idx;
      s2_idx_ff <= s1_idx_ff;
      s3_idx_ff <= s2_idx_ff;
      s4_idx_ff <= s3_idx_ff;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      d_ff      <= d_in;
      if (take) begin
         best_d_ff   <= d_ff;
         best_idx_ff <= s4_idx_ff;
      end
      if (cmd.emit) begin
         tag_ff       <= qid_ff;
         no_center_ff <= cmd.empty;
         nearest_ff   <= cmd.empty ? '0 : best_idx_ff[nca_pkg::NEAREST_BITS-1:0];
         dist_ff      <= cmd.empty ? '0 : best_d_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_point_tag = tag_ff;
   assign rsp_nearest   = nearest_ff;
   assign rsp_dist_sq   = dist_ff;
   assign rsp_no_center = no_center_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   a_first_center_taken: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && (s4_idx_ff == '0)) |=> (best_idx_ff == '0))
      else $error("first center did not seed the best");

endmodule

[rtl/core/nearest_center_assign.sv]
// Nearest center assignment. A load word (req_type 0) writes one center's x and y
// into table slot req_slot in the accept cycle; busy stays low. A query word
// (req_type 1) reads the centers below center_count from the table, one per cycle
// through its single read port, and feeds a five-stage distance pipeline; busy is
// high through the scan, drain and emit states after the accept edge (emit only
// if center_count is 0); rsp_valid pulses for one cycle right after busy falls,
// carrying point id, nearest index (lowest on ties) and squared distance. The
// receiver cannot stall: capture the result in the strobe cycle. A new word may
// be accepted in that same cycle. The table has no reset; querying a slot that
// was never loaded returns undefined results. Write center_count via the csr
// channel only while busy is low; values above MAX_CENTERS saturate.
module nearest_center_assign #(
   parameter int MAX_CENTERS = 256,
   parameter int COORD_BITS  = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic signed [COORD_BITS-1:0]      req_coord_x,
   input  logic signed [COORD_BITS-1:0]      req_coord_y,
   input  logic [nca_pkg::SLOT_BITS-1:0]     req_slot,
   input  logic [nca_pkg::ID_BITS-1:0]       req_point_id,
   output logic                              rsp_valid,
   output logic [nca_pkg::ID_BITS-1:0]       rsp_point_tag,
   output logic [nca_pkg::NEAREST_BITS-1:0]  rsp_nearest,
   output logic [nca_pkg::DIST_BITS-1:0]     rsp_dist_sq,
   output logic                              rsp_no_center,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nca_pkg::COUNT_BITS-1:0]    csr_data
);

   nca_pkg::cmd_type cmd;

   nca_ctrl #(
      .MAX_CENTERS (MAX_CENTERS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .busy      (busy),
      .cmd       (cmd)
   );

   nca_dp #(
      .MAX_CENTERS (MAX_CENTERS),
      .COORD_BITS  (COORD_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .req_slot      (req_slot),
      .req_point_id  (req_point_id),
      .rsp_valid     (rsp_valid),
      .rsp_point_tag (rsp_point_tag),
      .rsp_nearest   (rsp_nearest),
      .rsp_dist_sq   (rsp_dist_sq),
      .rsp_no_center (rsp_no_center)
   );

endmodule

[tb/sv/nca_checker.sv]
`timescale 1ns / 1ps
module nca_checker #(
   parameter int MAX_CENTERS = 256,
   parameter int COORD_BITS  = 24
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic                                      busy,
   input  logic                                      req_type,
   input  logic signed [COORD_BITS-1:0]              req_coord_x,
   input  logic signed [COORD_BITS-1:0]              req_coord_y,
   input  logic [nca_pkg::SLOT_BITS-1:0]             req_slot,
   input  logic [nca_pkg::ID_BITS-1:0]               req_point_id,
   input  logic                                      rsp_valid,
   input  logic [nca_pkg::ID_BITS-1:0]               rsp_point_tag,
   input  logic [nca_pkg::NEAREST_BITS-1:0]          rsp_nearest,
   input  logic [nca_pkg::DIST_BITS-1:0]             rsp_dist_sq,
   input  logic                                      rsp_no_center,
   input  logic                                      csr_valid,
   input  logic                                      csr_ready,
   input  logic [nca_pkg::COUNT_BITS-1:0]            csr_data,
   output int                                        error_count,
   output int                                        pending
);

   typedef struct packed {
      logic [nca_pkg::ID_BITS-1:0]      tag;
      logic [nca_pkg::NEAREST_BITS-1:0] nearest;
      logic [nca_pkg::DIST_BITS-1:0]    dist_sq;
      logic                             no_center;
   } assignment_type;

   logic signed [COORD_BITS-1:0] center_x [MAX_CENTERS];
   logic signed [COORD_BITS-1:0] center_y [MAX_CENTERS];
   int unsigned                  active_centers = 0;
   assignment_type               expected_assignments [$];
   int                           mismatches = 0;

   initial begin
      error_count = 0;
      pending     = 0;
   end

   function automatic logic [63:0] squared_distance(
      input logic signed [COORD_BITS-1:0] px, py, cx, cy
   );
      logic signed [COORD_BITS:0] dx, dy;
      logic [63:0]                mx, my, total;
      dx    = (COORD_BITS+1)'(px) - (COORD_BITS+1)'(cx);
      dy    = (COORD_BITS+1)'(py) - (COORD_BITS+1)'(cy);
      mx    = dx[COORD_BITS] ? 64'(-dx) : 64'(dx);
      my    = dy[COORD_BITS] ? 64'(-dy) : 64'(dy);
      total = mx * mx + my * my;
      return (total > 64'(nca_pkg::DIST_MAX)) ? 64'(nca_pkg::DIST_MAX) : total;
   endfunction

   function automatic assignment_type classify(
      input logic signed [COORD_BITS-1:0] px, py,
      input logic [nca_pkg::ID_BITS-1:0]  id
   );
      assignment_type r;
      logic [63:0]    d, best;
      r     = '0;
      r.tag = id;
      if (active_centers == 0) begin
         r.no_center = 1'b1;
         return r;
      end
      best = squared_distance(px, py, center_x[0], center_y[0]);
      for (int unsigned j = 1; j < active_centers; j++) begin
         d = squared_distance(px, py, center_x[j], center_y[j]);
         // strictly closer only: lowest index keeps ties
         if (d < best) begin
            best      = d;
            r.nearest = nca_pkg::NEAREST_BITS'(j);
         end
      end
      r.dist_sq = best[nca_pkg::DIST_BITS-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      assignment_type want, got;
      if (reset) begin
         active_centers = 0;
         expected_assignments.delete();
      end else begin
         if (rsp_valid) begin
            got.tag       = rsp_point_tag;
            got.nearest   = rsp_nearest;
            got.dist_sq   = rsp_dist_sq;
            got.no_center = rsp_no_center;
            if (expected_assignments.size() == 0) begin
               if (mismatches < 10)
                  $display("ERROR: rsp word with no pending query: %s %0d %0d %0d",
                           "tag nearest dist_sq", got.tag, got.nearest, got.dist_sq);
               mismatches++;
            end else begin
               want = expected_assignments.pop_front();
               if (got.tag !== want.tag || got.nearest !== want.nearest ||
                   got.dist_sq !== want.dist_sq || got.no_center !== want.no_center) begin
                  if (mismatches < 10)
                     $display({"ERROR: exp tag %0d nearest %0d dist_sq %0d empty %0b,",
                               " got tag %0d nearest %0d dist_sq %0d empty %0b"},
                              want.tag, want.nearest, want.dist_sq, want.no_center,
                              got.tag, got.nearest, got.dist_sq, got.no_center);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            if (req_type == nca_pkg::REQ_LOAD) begin
               if (req_slot < MAX_CENTERS) begin
                  center_x[req_slot] = req_coord_x;
                  center_y[req_slot] = req_coord_y;
               end
            end else begin
               expected_assignments.insert(expected_assignments.size(),
                  classify(req_coord_x, req_coord_y, req_point_id));
            end
         end
         if (csr_valid && csr_ready)
            active_centers = (csr_data > MAX_CENTERS) ? MAX_CENTERS : csr_data;
      end
      pending     <= expected_assignments.size();
      error_count <= mismatches;
   end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;

   localparam int MAX_CENTERS = 256;
   localparam int COORD_BITS  = 24;
   localparam int STALL_LIMIT = 2000;

   logic                                  clock        = 1'b0;
   logic                                  reset        = 1'b1;
   logic                                  start        = 1'b0;
   logic                                  req_type     = nca_pkg::REQ_LOAD;
   logic signed [COORD_BITS-1:0]          req_coord_x  = '0;
   logic signed [COORD_BITS-1:0]          req_coord_y  = '0;
   logic [nca_pkg::SLOT_BITS-1:0]         req_slot     = '0;
   logic [nca_pkg::ID_BITS-1:0]           req_point_id = '0;
   logic                                  csr_valid    = 1'b0;
   logic [nca_pkg::COUNT_BITS-1:0]        csr_data     = '0;
   logic                                  busy;
   logic                                  rsp_valid;
   logic [nca_pkg::ID_BITS-1:0]           rsp_point_tag;
   logic [nca_pkg::NEAREST_BITS-1:0]      rsp_nearest;
   logic [nca_pkg::DIST_BITS-1:0]         rsp_dist_sq;
   logic                                  rsp_no_center;
   logic                                  csr_ready;

   int error_count;
   int pending;
   int idle_pct     = 0;
   int stall_cycles = 0;

   always #5 clock = ~clock;

   nearest_center_assign #(
      .MAX_CENTERS(MAX_CENTERS),
      .COORD_BITS (COORD_BITS)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_type     (req_type),
      .req_coord_x  (req_coord_x),
      .req_coord_y  (req_coord_y),
      .req_slot     (req_slot),
      .req_point_id (req_point_id),
      .rsp_valid    (rsp_valid),
      .rsp_point_tag(rsp_point_tag),
      .rsp_nearest  (rsp_nearest),
      .rsp_dist_sq  (rsp_dist_sq),
      .rsp_no_center(rsp_no_center),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   nca_checker #(
      .MAX_CENTERS(MAX_CENTERS),
      .COORD_BITS (COORD_BITS)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_type     (req_type),
      .req_coord_x  (req_coord_x),
      .req_coord_y  (req_coord_y),
      .req_slot     (req_slot),
      .req_point_id (req_point_id),
      .rsp_valid    (rsp_valid),
      .rsp_point_tag(rsp_point_tag),
      .rsp_nearest  (rsp_nearest),
      .rsp_dist_sq  (rsp_dist_sq),
      .rsp_no_center(rsp_no_center),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .error_count  (error_count),
      .pending      (pending)
   );

   function automatic logic signed [COORD_BITS-1:0] pick_coord();
      logic signed [COORD_BITS-1:0] c;
      case ($urandom_range(9))
         0, 1, 2, 3: c = COORD_BITS'(int'($urandom_range(16)) - 8);
         8:          c = {1'b0, {(COORD_BITS-1){1'b1}}};
         9:          c = {1'b1, {(COORD_BITS-1){1'b0}}};
         default:    c = COORD_BITS'($urandom);
      endcase
      return c;
   endfunction

   function automatic logic [nca_pkg::COUNT_BITS-1:0] pick_count();
      logic [nca_pkg::COUNT_BITS-1:0] n;
      case ($urandom_range(19))
         0, 1:       n = '0;
         2, 3:       n = nca_pkg::COUNT_BITS'(1);
         12, 13, 14: n = nca_pkg::COUNT_BITS'($urandom_range(MAX_CENTERS));
         15, 16:     n = nca_pkg::COUNT_BITS'(MAX_CENTERS);
         17, 18:     n = nca_pkg::COUNT_BITS'($urandom_range(511, MAX_CENTERS + 1));
         19:         n = '1;
         default:    n = nca_pkg::COUNT_BITS'($urandom_range(16, 2));
      endcase
      return n;
   endfunction

   task automatic issue(
      input logic                          kind,
      input logic signed [COORD_BITS-1:0]  x, y,
      input logic [nca_pkg::SLOT_BITS-1:0] slot,
      input logic [nca_pkg::ID_BITS-1:0]   id
   );
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_type     <= kind;
      req_coord_x  <= x;
      req_coord_y  <= y;
      req_slot     <= slot;
      req_point_id <= id;
      do @(posedge clock); while (busy);
   endtask

   task automatic load_center(
      input logic [nca_pkg::SLOT_BITS-1:0] slot,
      input logic signed [COORD_BITS-1:0]  x, y
   );
      issue(nca_pkg::REQ_LOAD, x, y, slot, nca_pkg::ID_BITS'($urandom));
   endtask

   task automatic query_point(
      input logic signed [COORD_BITS-1:0] x, y,
      input logic [nca_pkg::ID_BITS-1:0]  id
   );
      issue(nca_pkg::REQ_QUERY, x, y, nca_pkg::SLOT_BITS'($urandom), id);
   endtask

   // hold off until every query has answered and the block has gone quiet
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_count(input logic [nca_pkg::COUNT_BITS-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int                           remaining;
      int                           round_len;
      logic                         first_round;
      logic signed [COORD_BITS-1:0] cmax, cmin;
      cmax = {1'b0, {(COORD_BITS-1){1'b1}}};
      cmin = {1'b1, {(COORD_BITS-1){1'b0}}};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty table
      query_point(cmax, cmax, '1);
      query_point(cmin, cmin, '0);

      load_center(nca_pkg::SLOT_BITS'(0), cmax, cmax);
      load_center(nca_pkg::SLOT_BITS'(1), cmin, cmin);
      load_center(nca_pkg::SLOT_BITS'(2), '0, '0);
      load_center(nca_pkg::SLOT_BITS'(3), '0, '0);
      load_center('1, COORD_BITS'(5), COORD_BITS'(-5));
      write_count(nca_pkg::COUNT_BITS'(4));
      query_point(cmin, cmin, nca_pkg::ID_BITS'(1));
      query_point(cmax, cmax, nca_pkg::ID_BITS'(2));
      query_point(COORD_BITS'(1), COORD_BITS'(1), nca_pkg::ID_BITS'(3));
      query_point('0, '0, nca_pkg::ID_BITS'(4));
      query_point(COORD_BITS'(-1), COORD_BITS'(1), nca_pkg::ID_BITS'(5));
      // single center, opposite corner: largest distance
      write_count(nca_pkg::COUNT_BITS'(1));
      query_point(cmin, cmin, nca_pkg::ID_BITS'(6));
      query_point(cmax, cmax, nca_pkg::ID_BITS'(7));
      write_count('0);
      query_point(COORD_BITS'(3), COORD_BITS'(-3), nca_pkg::ID_BITS'(8));

      for (int s = 0; s < MAX_CENTERS; s++)
         load_center(nca_pkg::SLOT_BITS'(s), pick_coord(), pick_coord());

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct    = (phase == 0) ? 37 : (phase == 1) ? 51 : 0;
         remaining   = 43;
         first_round = 1'b1;
         while (remaining > 0) begin
            if (first_round)
               write_count((phase == 0) ? '1 :
                           (phase == 1) ? nca_pkg::COUNT_BITS'(MAX_CENTERS) :
                                          nca_pkg::COUNT_BITS'(1));
            else
               write_count(pick_count());
            first_round = 1'b0;
            round_len   = $urandom_range(24, 4);
            if (round_len > remaining)
               round_len = remaining;
            repeat (round_len) begin
               if ($urandom_range(3) == 0)
                  load_center(nca_pkg::SLOT_BITS'($urandom), pick_coord(), pick_coord());
               else
                  query_point(pick_coord(), pick_coord(), nca_pkg::ID_BITS'($urandom));
               remaining--;
            end
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
